// ===== design/ordered_list_insert_delete_unit_assert.svh =====
// ----------------------------------------------------------------------------
// ordered list unit assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// same-cycle implication
`define OLID_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list unit: same-cycle check failed");

// next-cycle implication
`define OLID_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list unit: next-cycle check failed");

`endif

// ===== design/olid_pkg.sv =====
// ----------------------------------------------------------------------------
// olid_pkg
// types and constants shared by the ordered list unit files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olid_pkg;

   localparam int OLID_DEPTH   = 16;
   localparam int OLID_VALUE_W = 32;

   typedef enum logic [1:0] {
      KIND_INS_FRONT = 2'd0,
      KIND_INS_BACK  = 2'd1,
      KIND_DELETE    = 2'd2,
      KIND_DUMP      = 2'd3
   } olid_kind_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_EMPTY     = 2'd3
   } olid_status_type;

   typedef struct packed {
      olid_kind_type                   kind;
      logic signed [OLID_VALUE_W-1:0]  operand_value;
   } olid_req_type;

   typedef struct packed {
      olid_status_type                 status;
      logic signed [OLID_VALUE_W-1:0]  entry_value;
      logic                            last;
   } olid_rsp_type;

endpackage

// ===== design/olid_stream_if.sv =====
// ----------------------------------------------------------------------------
// olid_stream_if
// valid/ready word channel with source and sink views
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface olid_stream_if #(
   parameter type payload_type = olid_pkg::olid_req_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ordered_list_insert_delete_unit.sv =====
// order: an insert is done and its word registered in ST_EXEC; a delete walks the
//   list in ST_SCAN and answers from ST_FINISH; a dump reads it out in ST_DUMP
// throughput: one request at a time, the next is taken once the last word is built;
//   a delete walks the list one entry a cycle through the single read port of the
//   entry store; a dump reads it out one word a cycle when not stalled
// reset: synchronous, empties the list; the entry store itself is not cleared
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_unit
// ordered list of signed words kept as a ring in one synchronous memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_insert_delete_unit #(
   parameter int DEPTH = olid_pkg::OLID_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   olid_stream_if.sink   req_ch,
   olid_stream_if.source rsp_ch
);

   // ring index, count and sum widths
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int VW = olid_pkg::OLID_VALUE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINISH,
      ST_DUMP
   } state_type;

   // logical position to ring slot, one compare and subtract
   function automatic logic [IW-1:0] phys_of(input logic [IW-1:0] base,
                                             input logic [CW-1:0] offs);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(offs);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   // control state
   state_type                   state_ff;
   olid_pkg::olid_kind_type     kind_ff;
   logic signed [VW-1:0]        val_ff;
   logic [CW-1:0]               count_ff;
   logic [IW-1:0]               head_ff;
   logic [CW-1:0]               rd_idx_ff;   // next logical entry to read
   logic                        found_ff;
   logic [IW-1:0]               prev_phys_ff; // slot of the entry just examined

   // read pipeline tags, aligned with rd_data_ff
   logic                        rdv_ff;
   logic                        rd_last_ff;
   logic [IW-1:0]               rd_phys_ff;
   logic signed [VW-1:0]        rd_data_ff;

   // output word register
   logic                        out_valid_ff;
   olid_pkg::olid_rsp_type      out_word_ff;

   // entry store, front of list at head_ff
   logic signed [VW-1:0]        mem [DEPTH];

   logic                        out_free;
   logic                        full;
   logic [IW-1:0]               head_dec;
   logic [IW-1:0]               rd_phys;
   logic [IW-1:0]               back_phys;
   logic                        mem_re;
   logic                        mem_we;
   logic [IW-1:0]               mem_waddr;
   logic signed [VW-1:0]        mem_wdata;
   logic                        consume;
   logic                        rd_last_in;

   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign full       = (count_ff == CW'(DEPTH));
   assign head_dec   = (head_ff == '0) ? IW'(DEPTH - 1) : head_ff - IW'(1);
   assign rd_phys    = phys_of(head_ff, rd_idx_ff);
   assign back_phys  = phys_of(head_ff, count_ff);
   assign rd_last_in = (rd_idx_ff == count_ff - CW'(1));

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_word_ff;

   // read issue: delete scans freely, dump only when the data slot will drain
   always_comb begin
      mem_re  = 1'b0;
      consume = 1'b0;
      case (state_ff)
         ST_SCAN: begin
            mem_re  = (rd_idx_ff != count_ff);
            consume = rdv_ff;
         end
         ST_DUMP: begin
            mem_re  = (rd_idx_ff != count_ff) && (!rdv_ff || out_free);
            consume = rdv_ff && out_free;
         end
         default: begin
            mem_re  = 1'b0;
            consume = 1'b0;
         end
      endcase
   end

   // writes: insert at a ring end, or slide entries behind a deleted one forward
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = back_phys;
      mem_wdata = val_ff;
      case (state_ff)
         ST_EXEC: begin
            if (out_free && !full) begin
               if (kind_ff == olid_pkg::KIND_INS_FRONT) begin
                  mem_we    = 1'b1;
                  mem_waddr = head_dec;
               end else if (kind_ff == olid_pkg::KIND_INS_BACK) begin
                  mem_we    = 1'b1;
                  mem_waddr = back_phys;
               end
            end
         end
         ST_SCAN: begin
            if (rdv_ff && found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = prev_phys_ff;
               mem_wdata = rd_data_ff;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // entry store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_phys];
      end
   end

   // read tags
   always_ff @(posedge clock) begin
      if (reset) begin
         rdv_ff <= 1'b0;
      end else if (mem_re) begin
         rdv_ff <= 1'b1;
      end else if (consume) begin
         rdv_ff <= 1'b0;
      end
      if (mem_re) begin
         rd_last_ff <= rd_last_in;
         rd_phys_ff <= rd_phys;
      end
   end

   // sequencer and output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rd_idx_ff    <= '0;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (mem_re) begin
            rd_idx_ff <= rd_idx_ff + CW'(1);
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_ch.valid) begin
                  kind_ff  <= req_ch.payload.kind;
                  val_ff   <= req_ch.payload.operand_value;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               case (kind_ff)
                  olid_pkg::KIND_INS_FRONT,
                  olid_pkg::KIND_INS_BACK: begin
                     if (out_free) begin
                        out_valid_ff            <= 1'b1;
                        out_word_ff.status      <= full ? olid_pkg::STAT_FULL
                                                        : olid_pkg::STAT_OK;
                        out_word_ff.entry_value <= val_ff;
                        out_word_ff.last        <= 1'b1;
                        if (!full) begin
                           count_ff <= count_ff + CW'(1);
                           if (kind_ff == olid_pkg::KIND_INS_FRONT) begin
                              head_ff <= head_dec;
                           end
                        end
                        state_ff <= ST_IDLE;
                     end
                  end
                  olid_pkg::KIND_DELETE: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           out_valid_ff            <= 1'b1;
                           out_word_ff.status      <= olid_pkg::STAT_EMPTY;
                           out_word_ff.entry_value <= val_ff;
                           out_word_ff.last        <= 1'b1;
                           state_ff                <= ST_IDLE;
                        end
                     end else begin
                        rd_idx_ff <= '0;
                        found_ff  <= 1'b0;
                        state_ff  <= ST_SCAN;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        if (out_free) begin
                           out_valid_ff            <= 1'b1;
                           out_word_ff.status      <= olid_pkg::STAT_EMPTY;
                           out_word_ff.entry_value <= '0;
                           out_word_ff.last        <= 1'b1;
                           state_ff                <= ST_IDLE;
                        end
                     end else begin
                        rd_idx_ff <= '0;
                        state_ff  <= ST_DUMP;
                     end
                  end
               endcase
            end
            ST_SCAN: begin
               // first match sets found; later entries move one slot forward
               if (rdv_ff) begin
                  prev_phys_ff <= rd_phys_ff;
                  if (!found_ff && (rd_data_ff == val_ff)) begin
                     found_ff <= 1'b1;
                  end
                  if (rd_last_ff) begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  out_valid_ff            <= 1'b1;
                  out_word_ff.status      <= found_ff ? olid_pkg::STAT_OK
                                                      : olid_pkg::STAT_NOT_FOUND;
                  out_word_ff.entry_value <= val_ff;
                  out_word_ff.last        <= 1'b1;
                  if (found_ff) begin
                     count_ff <= count_ff - CW'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_DUMP: begin
               if (consume) begin
                  out_valid_ff            <= 1'b1;
                  out_word_ff.status      <= olid_pkg::STAT_OK;
                  out_word_ff.entry_value <= rd_data_ff;
                  out_word_ff.last        <= rd_last_ff;
                  if (rd_last_ff) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/olid_checker.sv =====
// ----------------------------------------------------------------------------
// olid_checker
// port-level checks for the ordered list unit, bound into the unit module
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ordered_list_insert_delete_unit_assert.svh"

module olid_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input olid_pkg::olid_status_type              rsp_status,
   input logic signed [olid_pkg::OLID_VALUE_W-1:0] rsp_value,
   input logic                                   rsp_last
);

   // a stalled word stays offered
   `OLID_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled word keeps its value
   `OLID_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_value))

   // error words always close their request
   `OLID_ASSERT_IMP(a_err_last, clock, reset, rsp_valid && (rsp_status != olid_pkg::STAT_OK), rsp_last)

   // one request at a time: busy right after an accept
   `OLID_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind ordered_list_insert_delete_unit olid_checker u_olid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.payload.status),
   .rsp_value  (rsp_ch.payload.entry_value),
   .rsp_last   (rsp_ch.payload.last)
);

// ===== verif/ordered_list_insert_delete_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_unit_tb
// insert, delete and dump requests against a shadow copy of the list,
// each response word checked field by field against the oldest prediction,
// idling on both channels, a long response hold-off and a full drain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_insert_delete_unit_tb;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 12;
   localparam int HOLD_CYCLES    = 300;   // long response stall, fills the unit up
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int DRAIN_CYCLES   = olid_pkg::OLID_DEPTH + 8;
   localparam int PHASE_ITEMS    = 65;

   typedef logic signed [olid_pkg::OLID_VALUE_W-1:0] word_value_type;

   localparam word_value_type VALUE_MIN = {1'b1, {(olid_pkg::OLID_VALUE_W-1){1'b0}}};
   localparam word_value_type VALUE_MAX = {1'b0, {(olid_pkg::OLID_VALUE_W-1){1'b1}}};

   logic clock;
   logic reset;

   olid_stream_if #(.payload_type(olid_pkg::olid_req_type)) req_if ();
   olid_stream_if #(.payload_type(olid_pkg::olid_rsp_type)) rsp_if ();

   ordered_list_insert_delete_unit #(
      .DEPTH (olid_pkg::OLID_DEPTH)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // shadow of the list contents, front at index 0
   word_value_type         shadow_list[$];
   // response words still owed by the unit, oldest first
   olid_pkg::olid_rsp_type expected_words[$];

   int error_count   = 0;
   int send_idle_pct = 0;   // only touched by the stimulus process
   int recv_idle_pct;       // written with nba, read by the response process
   int hold_trigger;        // bumped to request a long response hold-off
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   bit growing       = 1'b1;

   // ---------------------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // list prediction
   // ---------------------------------------------------------------------------
   function automatic void expect_word(olid_pkg::olid_status_type status,
                                       word_value_type value, logic last);
      olid_pkg::olid_rsp_type word;
      word.status      = status;
      word.entry_value = value;
      word.last        = last;
      expected_words.push_back(word);
   endfunction

   // applies one accepted request to the shadow list and queues its responses
   function automatic void predict_list_op(olid_pkg::olid_kind_type kind,
                                           word_value_type operand);
      int hit;
      hit = -1;
      case (kind)
         olid_pkg::KIND_INS_FRONT, olid_pkg::KIND_INS_BACK: begin
            if (shadow_list.size() >= olid_pkg::OLID_DEPTH) begin
               // full list: request dropped, list untouched
               expect_word(olid_pkg::STAT_FULL, operand, 1'b1);
            end else begin
               if (kind == olid_pkg::KIND_INS_FRONT) shadow_list.push_front(operand);
               else shadow_list.push_back(operand);
               expect_word(olid_pkg::STAT_OK, operand, 1'b1);
            end
         end
         olid_pkg::KIND_DELETE: begin
            if (shadow_list.size() == 0) begin
               expect_word(olid_pkg::STAT_EMPTY, operand, 1'b1);
            end else begin
               // only the match nearest the front goes
               foreach (shadow_list[i]) begin
                  if (hit < 0 && shadow_list[i] == operand) hit = i;
               end
               if (hit < 0) begin
                  expect_word(olid_pkg::STAT_NOT_FOUND, operand, 1'b1);
               end else begin
                  shadow_list.delete(hit);
                  expect_word(olid_pkg::STAT_OK, operand, 1'b1);
               end
            end
         end
         default: begin
            // dump: empty list gives a single empty word with value zero
            if (shadow_list.size() == 0) begin
               expect_word(olid_pkg::STAT_EMPTY, '0, 1'b1);
            end else begin
               foreach (shadow_list[i]) begin
                  expect_word(olid_pkg::STAT_OK, shadow_list[i],
                              (i == shadow_list.size() - 1));
               end
            end
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // response checking and ready driving
   // ---------------------------------------------------------------------------
   function automatic void note_mismatch(string field, longint want, longint got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
   endfunction

   function automatic void check_word(olid_pkg::olid_rsp_type got);
      olid_pkg::olid_rsp_type want;
      if (expected_words.size() == 0) begin
         error_count++;
         $display("%0t: unexpected word, expected none actual status %0d value %0d last %0b",
                  $time, got.status, got.entry_value, got.last);
         return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status)
         note_mismatch("status", want.status, got.status);
      if (got.entry_value !== want.entry_value)
         note_mismatch("entry_value", want.entry_value, got.entry_value);
      if (got.last !== want.last)
         note_mismatch("last", want.last, got.last);
   endfunction

   // samples the accepted word with pre-edge values, then picks next ready
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_word(rsp_if.payload);
         // a new hold-off request restarts the stall counter
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // watchdog: nothing moving on either channel for too long ends the run
   // ---------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------
   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   // offers one request word and waits for it to be taken; valid stays high
   // afterwards so back-to-back words never drop it within one step
   task automatic send_request(olid_pkg::olid_kind_type kind, word_value_type operand);
      olid_pkg::olid_req_type word;
      word.kind          = kind;
      word.operand_value = operand;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= word;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_list_op(kind, operand);
   endtask

   // stop offering and wait until every predicted word has come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   // mix of small values for duplicates, extremes and full-range values
   function automatic word_value_type random_operand();
      case ($urandom_range(3))
         0: return word_value_type'(int'($urandom_range(6)) - 3);
         1: begin
            case ($urandom_range(3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return word_value_type'($urandom);
      endcase
   endfunction

   // list size swings between empty and full so both edges get hit often
   task automatic send_random_op();
      int roll;
      int count;
      olid_pkg::olid_kind_type kind;
      word_value_type value;
      count = shadow_list.size();
      if (count == olid_pkg::OLID_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      else if (count == 0 && $urandom_range(1) == 0) growing = 1'b1;
      roll = $urandom_range(99);
      if (roll < 15)
         kind = olid_pkg::KIND_DUMP;
      else if (roll < (growing ? 80 : 35))
         kind = $urandom_range(1) ? olid_pkg::KIND_INS_BACK : olid_pkg::KIND_INS_FRONT;
      else
         kind = olid_pkg::KIND_DELETE;
      value = random_operand();
      // deletes mostly aim at a value that is really in the list
      if (kind == olid_pkg::KIND_DELETE && count > 0 && $urandom_range(3) != 0)
         value = shadow_list[$urandom_range(count - 1)];
      send_request(kind, value);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   // dump and delete on a list that was just emptied by reset
   task automatic test_empty_list();
      send_request(olid_pkg::KIND_DUMP, word_value_type'($urandom));
      send_request(olid_pkg::KIND_DELETE, VALUE_MIN);
   endtask

   // extreme operand values at both ends of the list
   task automatic test_value_extremes();
      send_request(olid_pkg::KIND_INS_FRONT, VALUE_MIN);
      send_request(olid_pkg::KIND_INS_BACK, VALUE_MAX);
      send_request(olid_pkg::KIND_INS_FRONT, '1);
   endtask

   // duplicates: delete takes the one nearest the front; absent value flagged
   task automatic test_duplicate_delete();
      send_request(olid_pkg::KIND_INS_BACK, word_value_type'(5));
      send_request(olid_pkg::KIND_INS_FRONT, word_value_type'(5));
      send_request(olid_pkg::KIND_INS_BACK, word_value_type'(7));
      send_request(olid_pkg::KIND_DELETE, word_value_type'(5));
      send_request(olid_pkg::KIND_DELETE, word_value_type'(12345));
   endtask

   // fill to capacity, overflow at both ends, then dump the full list
   task automatic test_fill_and_overflow();
      while (shadow_list.size() < olid_pkg::OLID_DEPTH)
         send_request($urandom_range(1) ? olid_pkg::KIND_INS_FRONT
                                        : olid_pkg::KIND_INS_BACK,
                      word_value_type'($urandom));
      send_request(olid_pkg::KIND_INS_FRONT, VALUE_MAX);
      send_request(olid_pkg::KIND_INS_BACK, VALUE_MIN);
      send_request(olid_pkg::KIND_DUMP, '0);
   endtask

   task automatic test_random_ops(int count);
      repeat (count) send_random_op();
   endtask

   // response side stalls for a long stretch while requests keep coming,
   // so the unit backs up; then the sender waits for a full drain
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_trigger <= hold_trigger + 1;
      send_request(olid_pkg::KIND_DUMP, random_operand());
      repeat (10) send_random_op();
      send_request(olid_pkg::KIND_DUMP, random_operand());
      drain_results();
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      hold_trigger   <= 0;
      recv_idle_pct  <= 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver heavily
      set_idling(22, 53);
      test_empty_list();
      test_value_extremes();
      test_duplicate_delete();
      test_fill_and_overflow();
      test_random_ops(PHASE_ITEMS);
      test_backpressure();

      // sender idles heavily, receiver lightly
      set_idling(53, 22);
      test_random_ops(PHASE_ITEMS);

      // no idling at all
      set_idling(0, 0);
      test_random_ops(PHASE_ITEMS);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         error_count++;
         $display("%0t: %0d words never arrived, expected %0d actual 0",
                  $time, expected_words.size(), expected_words.size());
      end
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== ordered_list_insert_delete_unit.f =====
+incdir+design
design/olid_pkg.sv
design/olid_stream_if.sv
design/ordered_list_insert_delete_unit.sv
design/olid_checker.sv
verif/ordered_list_insert_delete_unit_tb.sv
